/* src/i64d_pkg.sv */
// Shared constants and types for the pipelined integer divider.
package i64d_pkg;

  // Width of the operand and result ports.
  localparam int PORT_W = 64;

  // Default arithmetic width of the divider.
  localparam int WIDTH_DEF = 64;

  // Side information that travels with each word down the pipeline.
  typedef struct packed {
    logic valid;
    logic q_neg;
    logic r_neg;
    logic zero;
  } i64d_ctl_t;

endpackage

/* src/i64d_stage.sv */
// One restoring-division step: trial subtract, select, shift in one quotient bit.
module i64d_stage #(
  parameter int WIDTH = i64d_pkg::WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i64d_pkg::i64d_ctl_t   ctl_i,
  input  logic [WIDTH-1:0]      rem_i,
  input  logic [WIDTH-1:0]      nq_i,
  input  logic [WIDTH-1:0]      den_i,
  output i64d_pkg::i64d_ctl_t   ctl_o,
  output logic [WIDTH-1:0]      rem_o,
  output logic [WIDTH-1:0]      nq_o,
  output logic [WIDTH-1:0]      den_o
);

  i64d_pkg::i64d_ctl_t ctl_r;
  logic [WIDTH-1:0]    rem_r, rem_nxt;
  logic [WIDTH-1:0]    nq_r, nq_nxt;
  logic [WIDTH-1:0]    den_r;
  logic [WIDTH:0]      trial;
  logic [WIDTH:0]      diff;
  logic                q_bit;

  // nq holds the unused dividend bits on top and the quotient bits below.
  always_comb begin
    trial   = {rem_i, nq_i[WIDTH-1]};
    diff    = trial - {1'b0, den_i};
    q_bit   = ~diff[WIDTH];
    rem_nxt = q_bit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    nq_nxt  = {nq_i[WIDTH-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    nq_r  <= nq_nxt;
    den_r <= den_i;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign nq_o  = nq_r;
  assign den_o = den_r;

endmodule

/* src/int64_divider.sv */
// Pipelined signed/unsigned integer divider, top level.
//
// Input channel: drive in_command, in_dividend and in_divisor with start high;
// the word is taken at the rising edge where start is high and busy is low.
// busy is set by reset and clears at the first clock edge with rst_n high, so
// once busy is low a new division may enter on every cycle.
// Result channel: out_valid is high for exactly one cycle with out_quotient,
// out_remainder and out_zero_divisor; the receiver must take the word then.
// From the accepting edge a word passes the operand register, which takes the
// operand magnitudes, one pipeline stage per quotient bit (each a WIDTH+1 bit
// trial subtract), and the output register, which holds the sign fixup.
// Throughput is one division per cycle once busy is low.
// Signed mode divides magnitudes, negates the quotient when the signs differ
// and gives the remainder the sign of the dividend. A zero divisor yields an
// all-ones magnitude quotient and the dividend as remainder, flagged by
// out_zero_divisor.
// Reset clears every valid bit in the pipeline; words in flight are dropped.
module int64_divider #(
  parameter int WIDTH = i64d_pkg::WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [i64d_pkg::PORT_W-1:0]  in_dividend,
  input  logic [i64d_pkg::PORT_W-1:0]  in_divisor,
  output logic                         out_valid,
  output logic [i64d_pkg::PORT_W-1:0]  out_quotient,
  output logic [i64d_pkg::PORT_W-1:0]  out_remainder,
  output logic                         out_zero_divisor
);

  localparam int LAT = WIDTH + 2;

  logic                busy_r;

  // Operand stage.
  i64d_pkg::i64d_ctl_t ctl_in_r, ctl_in_nxt;
  logic [WIDTH-1:0]    num_in_r, num_in_nxt;
  logic [WIDTH-1:0]    den_in_r, den_in_nxt;
  logic [WIDTH-1:0]    n_w, d_w;
  logic                n_neg, d_neg;

  // Division stages.
  i64d_pkg::i64d_ctl_t ctl_s [0:WIDTH];
  logic [WIDTH-1:0]    rem_s [0:WIDTH];
  logic [WIDTH-1:0]    nq_s  [0:WIDTH];
  logic [WIDTH-1:0]    den_s [0:WIDTH];

  // Output stage.
  logic                out_valid_r;
  logic                out_zero_r;
  logic [WIDTH-1:0]    quo_r, quo_nxt;
  logic [WIDTH-1:0]    rem_r, rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  always_comb begin
    n_w   = in_dividend[WIDTH-1:0];
    d_w   = in_divisor[WIDTH-1:0];
    n_neg = in_command & n_w[WIDTH-1];
    d_neg = in_command & d_w[WIDTH-1];
    num_in_nxt       = n_neg ? (~n_w + 1'b1) : n_w;
    den_in_nxt       = d_neg ? (~d_w + 1'b1) : d_w;
    ctl_in_nxt.valid = start & ~busy_r;
    ctl_in_nxt.q_neg = n_neg ^ d_neg;
    ctl_in_nxt.r_neg = n_neg;
    ctl_in_nxt.zero  = (d_w == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_in_r <= '0;
    end else begin
      ctl_in_r <= ctl_in_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_in_r <= num_in_nxt;
    den_in_r <= den_in_nxt;
  end

  assign ctl_s[0] = ctl_in_r;
  assign rem_s[0] = '0;
  assign nq_s[0]  = num_in_r;
  assign den_s[0] = den_in_r;

  for (genvar k = 0; k < WIDTH; k++) begin : g_step
    i64d_stage #(
      .WIDTH (WIDTH)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_s[k]),
      .rem_i (rem_s[k]),
      .nq_i  (nq_s[k]),
      .den_i (den_s[k]),
      .ctl_o (ctl_s[k+1]),
      .rem_o (rem_s[k+1]),
      .nq_o  (nq_s[k+1]),
      .den_o (den_s[k+1])
    );
  end

  // Apply signs to the magnitude results.
  always_comb begin
    quo_nxt = ctl_s[WIDTH].q_neg ? (~nq_s[WIDTH] + 1'b1) : nq_s[WIDTH];
    rem_nxt = ctl_s[WIDTH].r_neg ? (~rem_s[WIDTH] + 1'b1) : rem_s[WIDTH];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl_s[WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    out_zero_r <= ctl_s[WIDTH].zero;
  end

  assign out_valid        = out_valid_r;
  assign out_quotient     = i64d_pkg::PORT_W'(quo_r);
  assign out_remainder    = i64d_pkg::PORT_W'(rem_r);
  assign out_zero_divisor = out_zero_r;

  // Every result word comes from a matching accepted word.
  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result word without a matching accepted word");

  // A zero divisor returns the dividend as remainder.
  a_zero_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_divisor) |->
      (out_remainder == i64d_pkg::PORT_W'($past(in_dividend[WIDTH-1:0], LAT))))
    else $error("zero divisor remainder differs from dividend");

  // Unsigned remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_zero_divisor && !$past(in_command, LAT)) |->
      (out_remainder < i64d_pkg::PORT_W'($past(in_divisor[WIDTH-1:0], LAT))))
    else $error("unsigned remainder not below divisor");

  // Once busy has cleared after reset, the divider never refuses a word.
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule
